/* rtl/modbus_rtu_response_checker_top_assert.svh */
// Assertion macros shared by the Modbus RTU response checker RTL.
// Each macro expands to one labeled concurrent assertion on a clock and an active-low reset.
`ifndef MODBUS_RTU_RESPONSE_CHECKER_TOP_ASSERT_SVH
`define MODBUS_RTU_RESPONSE_CHECKER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MRC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mrc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mrc assertion failed");

`endif

/* rtl/mrc_pkg.sv */
// Shared types, constants and the CRC-16 byte fold for the Modbus RTU response checker.
// No dependencies.
`default_nettype none

package mrc_pkg;

    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [7:0]  EXC_BIT   = 8'h80;
    localparam logic [2:0]  COUNT_MAX = 3'd5;
    localparam logic [2:0]  MIN_LEN   = 3'd4;
    localparam logic [2:0]  EXC_LEN   = 3'd5;
    localparam int          OUT_TDATA_W = 48;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SHORT     = 2'd1,
        ST_CRC_ERR   = 2'd2,
        ST_EXCEPTION = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  exception_code;
        logic [15:0] computed_crc;
        logic [15:0] received_crc;
        status_t     status;
    } verdict_t;

    // One byte through the reflected CRC-16, one bit per step.
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/mrc_in_reg.sv */
// Input register of the Modbus RTU response checker: holds one received byte and its flag.
// Depends on mrc_pkg.
`default_nettype none

module mrc_in_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire mrc_pkg::in_item_t s_item,
    input  wire logic              out_space,
    output logic                   adv,
    output mrc_pkg::in_item_t      item
);

    logic              valid_reg;
    logic              valid_next;
    mrc_pkg::in_item_t item_reg;

    // A final byte may only move on when the result register can take its verdict.
    assign adv        = valid_reg && (!item_reg.last || out_space);
    assign s_tready   = !valid_reg || adv;
    assign valid_next = s_tready ? s_tvalid : valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            item_reg <= s_item;
    end

endmodule

`default_nettype wire

/* rtl/mrc_core.sv */
// Frame state and verdict logic: delay line, running CRC, byte count and captured bytes.
// Depends on mrc_pkg and the assertion macro header.
`default_nettype none
`include "modbus_rtu_response_checker_top_assert.svh"

module mrc_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire mrc_pkg::in_item_t item,
    output mrc_pkg::verdict_t      verdict
);

    logic [15:0] crc_reg,   crc_next;
    logic [7:0]  older_reg, older_next;
    logic [7:0]  newer_reg, newer_next;
    logic [2:0]  cnt_reg,   cnt_next;
    logic [7:0]  func_reg,  func_next;
    logic [7:0]  third_reg, third_next;
    logic [15:0] rx_crc;

    // A byte enters the CRC only once two newer bytes sit behind it.
    always_comb
    begin
        crc_next   = (cnt_reg >= 3'd2) ? mrc_pkg::crc_fold(crc_reg, older_reg) : crc_reg;
        older_next = newer_reg;
        newer_next = item.frame_byte;
        func_next  = (cnt_reg == 3'd1) ? item.frame_byte : func_reg;
        third_next = (cnt_reg == 3'd2) ? item.frame_byte : third_reg;
        cnt_next   = (cnt_reg < mrc_pkg::COUNT_MAX) ? cnt_reg + 3'd1 : cnt_reg;
        rx_crc     = {newer_next, older_next};

        verdict.received_crc   = rx_crc;
        verdict.computed_crc   = crc_next;
        verdict.exception_code = 8'h00;
        if (cnt_next < mrc_pkg::MIN_LEN)
            verdict.status = mrc_pkg::ST_SHORT;
        else if (rx_crc != crc_next)
            verdict.status = mrc_pkg::ST_CRC_ERR;
        else if ((cnt_next >= mrc_pkg::EXC_LEN) && ((func_next & mrc_pkg::EXC_BIT) != 8'h00))
        begin
            verdict.status         = mrc_pkg::ST_EXCEPTION;
            verdict.exception_code = third_next;
        end
        else
            verdict.status = mrc_pkg::ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= mrc_pkg::CRC_INIT;
            older_reg <= 8'h00;
            newer_reg <= 8'h00;
            cnt_reg   <= 3'd0;
            func_reg  <= 8'h00;
            third_reg <= 8'h00;
        end
        else if (adv)
        begin
            if (item.last)
            begin
                crc_reg   <= mrc_pkg::CRC_INIT;
                older_reg <= 8'h00;
                newer_reg <= 8'h00;
                cnt_reg   <= 3'd0;
                func_reg  <= 8'h00;
                third_reg <= 8'h00;
            end
            else
            begin
                crc_reg   <= crc_next;
                older_reg <= older_next;
                newer_reg <= newer_next;
                cnt_reg   <= cnt_next;
                func_reg  <= func_next;
                third_reg <= third_next;
            end
        end
    end

    `MRC_ASSERT_NEXT(a_cnt_clear, clk, rst_n, adv && item.last, cnt_reg == 3'd0)
    `MRC_ASSERT_NEXT(a_crc_clear, clk, rst_n, adv && item.last, crc_reg == mrc_pkg::CRC_INIT)
    `MRC_ASSERT_NEXT(a_cnt_moves, clk, rst_n, adv && !item.last, cnt_reg != 3'd0)
    `MRC_ASSERT_SAME(a_cnt_range, clk, rst_n, 1'b1, cnt_reg <= mrc_pkg::COUNT_MAX)

endmodule

`default_nettype wire

/* rtl/mrc_out_reg.sv */
// Result register of the Modbus RTU response checker: holds one verdict until taken.
// Depends on mrc_pkg.
`default_nettype none

module mrc_out_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire mrc_pkg::verdict_t verdict,
    output logic                   out_space,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output mrc_pkg::verdict_t      m_verdict
);

    logic              valid_reg;
    logic              valid_next;
    mrc_pkg::verdict_t verdict_reg;

    assign out_space  = !valid_reg || m_tready;
    assign valid_next = load || (valid_reg && !m_tready);
    assign m_tvalid   = valid_reg;
    assign m_verdict  = verdict_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            verdict_reg <= verdict;
    end

endmodule

`default_nettype wire

/* rtl/modbus_rtu_response_checker_top.sv */
// Top level of the Modbus RTU response checker: input register, frame core, result register.
// Depends on mrc_pkg, mrc_in_reg, mrc_core and mrc_out_reg.
//
// Usage:
// Received response bytes enter on the s_ stream, one byte per request, with s_tlast
// high on the final byte of the frame. Every final byte yields exactly one verdict
// request on the m_ stream; other bytes yield nothing. The verdict carries the status
// (ok, too short, CRC mismatch, Modbus exception), the received and computed CRC-16
// and the exception code.
// Throughput is one byte per cycle while no final byte waits for the result register;
// a byte is registered in the input register, and the CRC fold over it is one pass of
// combinational logic into the frame state. m_tvalid rises once the final byte has
// moved on from the input register to the result register; the verdict can then be taken.
// After reset both registers are empty and the frame state is cleared (CRC 0xFFFF,
// count zero); each final byte also clears it for the next frame.
// When the receiver stalls, the verdict waits in the result register; non-final bytes
// keep flowing, and a final byte waits in the input register, holding s_tready low,
// until the result register frees up.
`default_nettype none

module modbus_rtu_response_checker_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] frame_byte
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [1:0] status, [17:2] received_crc, [33:18] computed_crc,
    // [41:34] exception_code, [47:42] zero
    output logic [mrc_pkg::OUT_TDATA_W-1:0] m_tdata
);

    mrc_pkg::in_item_t s_item;
    mrc_pkg::in_item_t item;
    mrc_pkg::verdict_t verdict;
    mrc_pkg::verdict_t m_verdict;
    logic              adv;
    logic              out_space;

    assign s_item.frame_byte = s_tdata;
    assign s_item.last       = s_tlast;

    mrc_in_reg u_in_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_item    (s_item),
        .out_space (out_space),
        .adv       (adv),
        .item      (item)
    );

    mrc_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .item    (item),
        .verdict (verdict)
    );

    mrc_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (adv && item.last),
        .verdict   (verdict),
        .out_space (out_space),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_verdict (m_verdict)
    );

    assign m_tdata = {6'b000000, m_verdict};

endmodule

`default_nettype wire
